// File: design/assert_macros.svh
// assertion macros used by the checker file chse_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while aresetn is low
`define CHSE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked check that also holds during reset
`define CHSE_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: design/chse_pkg.sv
// types, constants and helpers for the three-lane chebyshev series evaluator
`timescale 1ns / 1ps

package chse_pkg;

    localparam int LANES      = 3;
    localparam int COORD_W    = 32;
    localparam int COEF_W     = 32;
    localparam int GAIN_W     = 31;
    localparam int VAL_W      = 40;
    localparam int SUM_W      = 50;
    localparam int OPA_W      = 34;
    localparam int OPB_W      = 50;
    localparam int PROD_W     = 49;
    localparam int CHUNK_W    = 17;
    localparam int CHUNKS     = 3;
    localparam int PROD_LIM_B = 47;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 31'd1073741824;

    localparam logic signed [SUM_W-1:0] SUM_V40_MAX = 50'sd549755813887;
    localparam logic signed [SUM_W-1:0] SUM_V40_MIN = -50'sd549755813888;

    localparam logic signed [VAL_W-1:0] V40_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [VAL_W-1:0] V40_MIN = 40'sh80_0000_0000;

    // multiplier step codes
    localparam logic [2:0] STEP_LAST_MAC = 3'd2;
    localparam logic [2:0] STEP_ROUND    = 3'd3;
    localparam logic [2:0] STEP_FINISH   = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1_GO,
        ST_MUL1_WAIT,
        ST_MUL2_GO,
        ST_MUL2_WAIT,
        ST_EMIT
    } state_t;

    // sequencer to lane controls
    typedef struct packed {
        logic clear;      // first coefficient of a run
        logic mul_start;
        logic mul_close;  // second multiply uses gain and closing sum
        logic update;     // non-final recurrence write-back
        logic close_sum;
        logic capture;
    } ctrl_t;

    function automatic logic signed [VAL_W-1:0] sat40(input logic signed [SUM_W-1:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > SUM_V40_MAX) begin
            r = V40_MAX;
        end else if (v < SUM_V40_MIN) begin
            r = V40_MIN;
        end else begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: design/chse_mulq.sv
// iterative signed multiply with round-half-away and clamp, 17 bits of b per cycle
`timescale 1ns / 1ps

module chse_mulq #(
    parameter int FRAC_BITS = 30
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic signed [chse_pkg::OPA_W-1:0]    op_a,
    input  logic signed [chse_pkg::OPB_W-1:0]    op_b,
    output logic signed [chse_pkg::PROD_W-1:0]   prod,
    output logic                                 done
);
    import chse_pkg::*;

    localparam int UA_W  = OPA_W - 1;
    localparam int UB_W  = CHUNK_W * CHUNKS;
    localparam int PP_W  = UA_W + CHUNK_W;
    localparam int ACC_W = UA_W + UB_W;
    localparam int MAG_W = PROD_LIM_B + 1;

    localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic [ACC_W-1:0] LIM_ACC  = ACC_W'(1) << PROD_LIM_B;
    localparam logic [MAG_W-1:0] LIM_MAG  = MAG_W'(1) << PROD_LIM_B;

    logic [UA_W-1:0]          ua_reg, ua_next;
    logic [UB_W-1:0]          ub_reg, ub_next;
    logic                     neg_reg, neg_next;
    logic [ACC_W-1:0]         acc_reg, acc_next;
    logic [2:0]               cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;

    logic [OPA_W-1:0] a_mag;
    logic [OPB_W-1:0] b_mag;
    logic [PP_W-1:0]  pp;
    logic [ACC_W-1:0] shifted;
    logic [MAG_W-1:0] mag;

    assign a_mag   = op_a[OPA_W-1] ? (~op_a + 1'b1) : op_a;
    assign b_mag   = op_b[OPB_W-1] ? (~op_b + 1'b1) : op_b;
    assign pp      = ua_reg * ub_reg[UB_W-1 -: CHUNK_W];
    assign shifted = acc_reg >> FRAC_BITS;
    assign mag     = (shifted > LIM_ACC) ? LIM_MAG : shifted[MAG_W-1:0];

    always_comb begin
        ua_next   = ua_reg;
        ub_next   = ub_reg;
        neg_next  = neg_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        prod_next = prod_reg;
        if (start) begin
            ua_next   = a_mag[UA_W-1:0];
            ub_next   = UB_W'(b_mag);
            neg_next  = op_a[OPA_W-1] ^ op_b[OPB_W-1];
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg <= STEP_LAST_MAC) begin
                // most significant chunk first
                acc_next = (acc_reg << CHUNK_W) + ACC_W'(pp);
                ub_next  = ub_reg << CHUNK_W;
            end else if (cnt_reg == STEP_ROUND) begin
                acc_next = acc_reg + RND_HALF;
            end else begin
                prod_next = neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
                done_next = 1'b1;
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        ua_reg   <= ua_next;
        ub_reg   <= ub_next;
        neg_reg  <= neg_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;
    assign done = done_reg;

endmodule

// File: design/chse_lane.sv
// one coordinate lane: clenshaw recurrence registers and closing step
`timescale 1ns / 1ps

module chse_lane #(
    parameter int FRAC_BITS = 30
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  chse_pkg::ctrl_t                       ctrl,
    input  logic signed [chse_pkg::COORD_W-1:0]   coord,
    input  logic signed [chse_pkg::COEF_W-1:0]    coef,
    input  logic                                  last,
    input  logic [chse_pkg::GAIN_W-1:0]           gain,
    output logic signed [chse_pkg::VAL_W-1:0]     res,
    output logic                                  done
);
    import chse_pkg::*;

    logic signed [VAL_W-1:0]  now_reg, now_next;
    logic signed [VAL_W-1:0]  prev_reg, prev_next;
    logic signed [SUM_W-1:0]  s_reg;
    logic signed [VAL_W-1:0]  res_reg;

    logic signed [OPA_W-1:0]  op_a;
    logic signed [OPB_W-1:0]  op_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0]  step_sum;
    logic signed [SUM_W-1:0]  close_sum;
    logic signed [COEF_W-1:0] half_coef;

    // floor(coef / 2)
    assign half_coef = coef >>> 1;

    always_comb begin
        if (ctrl.mul_close) begin
            op_a = $signed({3'b000, gain});
            op_b = s_reg;
        end else begin
            op_a = last ? OPA_W'(coord) : $signed({coord[COORD_W-1], coord, 1'b0});
            op_b = OPB_W'(now_reg);
        end
    end

    chse_mulq #(.FRAC_BITS(FRAC_BITS)) u_mulq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ctrl.mul_start),
        .op_a    (op_a),
        .op_b    (op_b),
        .prod    (prod),
        .done    (done)
    );

    assign step_sum  = SUM_W'(prod) - SUM_W'(prev_reg) + SUM_W'(coef);
    assign close_sum = SUM_W'(prod) - SUM_W'(prev_reg) + SUM_W'(half_coef);

    always_comb begin
        now_next  = now_reg;
        prev_next = prev_reg;
        if (ctrl.clear || ctrl.capture) begin
            now_next  = '0;
            prev_next = '0;
        end else if (ctrl.update) begin
            now_next  = sat40(step_sum);
            prev_next = now_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg  <= '0;
            prev_reg <= '0;
        end else begin
            now_reg  <= now_next;
            prev_reg <= prev_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.close_sum) begin
            s_reg <= close_sum;
        end
        if (ctrl.capture) begin
            res_reg <= sat40(SUM_W'(prod));
        end
    end

    assign res = res_reg;

endmodule

// File: design/chebyshev_series_eval_3d_unit.sv
// top level: request sequencer, three recurrence lanes and the result register
//
//  channel | direction | contents
//  s_      | in        | tdata: x, y, z, coef; tuser: first_coef; tlast: last_coef
//  m_      | out       | tdata: value_x, value_y, value_z
//  cfg_    | in        | gain write, no read-back
//
// each coefficient passes through the per-lane multiplier, which consumes 17
// bits of its wide operand per cycle; the final one adds a second multiply.
// the three lanes run in lockstep; the next request is taken while a result
// still waits in the output register. reset is synchronous, active low, and
// clears the recurrence state and the gain to 1.0.
`timescale 1ns / 1ps

module chebyshev_series_eval_3d_unit #(
    parameter int FRAC_BITS = 30
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [127:0]                          s_tdata,   // coord_x, coord_y, coord_z, coef
    input  logic [0:0]                            s_tuser,   // first_coef
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [119:0]                          m_tdata,   // value_x, value_y, value_z
    input  logic                                  cfg_wr_en,
    input  logic [chse_pkg::GAIN_W-1:0]           cfg_wr_data
);
    import chse_pkg::*;

    state_t state_reg, state_next;
    ctrl_t  ctrl;

    logic [GAIN_W-1:0]         gain_reg;
    logic signed [COORD_W-1:0] coord_reg [LANES];
    logic signed [COEF_W-1:0]  coef_reg;
    logic                      last_reg;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [119:0]              m_tdata_reg;

    logic signed [VAL_W-1:0]   lane_res  [LANES];
    logic [LANES-1:0]          lane_done;
    logic                      accept;
    logic                      all_done;
    logic                      out_free;

    assign accept   = s_tvalid && s_tready;
    assign all_done = &lane_done;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (s_tvalid) state_next = ST_MUL1_GO;
            ST_MUL1_GO:   state_next = ST_MUL1_WAIT;
            ST_MUL1_WAIT: begin
                if (all_done) begin
                    state_next = last_reg ? ST_MUL2_GO : ST_IDLE;
                end
            end
            ST_MUL2_GO:   state_next = ST_MUL2_WAIT;
            ST_MUL2_WAIT: if (all_done) state_next = ST_EMIT;
            ST_EMIT:      if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready       = 1'b0;
        ctrl           = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                ctrl.clear = s_tvalid && s_tuser[0];
            end
            ST_MUL1_GO: begin
                ctrl.mul_start = 1'b1;
            end
            ST_MUL1_WAIT: begin
                ctrl.update    = all_done && !last_reg;
                ctrl.close_sum = all_done && last_reg;
            end
            ST_MUL2_GO: begin
                ctrl.mul_start = 1'b1;
                ctrl.mul_close = 1'b1;
            end
            ST_MUL2_WAIT: begin
                ctrl.mul_close = 1'b1;
                ctrl.capture   = all_done;
            end
            ST_EMIT: begin
                ctrl.mul_close = 1'b1;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (state_reg == ST_EMIT && out_free) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            gain_reg     <= GAIN_RESET;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                gain_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            coord_reg[0] <= s_tdata[31:0];
            coord_reg[1] <= s_tdata[63:32];
            coord_reg[2] <= s_tdata[95:64];
            coef_reg     <= s_tdata[127:96];
            last_reg     <= s_tlast;
        end
        if (state_reg == ST_EMIT && out_free) begin
            m_tdata_reg <= {lane_res[2], lane_res[1], lane_res[0]};
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        chse_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .coord   (coord_reg[g]),
            .coef    (coef_reg),
            .last    (last_reg),
            .gain    (gain_reg),
            .res     (lane_res[g]),
            .done    (lane_done[g])
        );
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: design/chse_checker.sv
// port-level checks for the series evaluator, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module chse_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         s_tlast,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [119:0] m_tdata
);

    // a held result keeps its data
    `CHSE_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // no result survives reset
    `CHSE_ASSERT_RST(a_reset_empty, !aresetn |=> !m_tvalid, "result valid after reset")

    // one request at a time: the input closes right after a request
    `CHSE_ASSERT(a_one_request, s_tvalid && s_tready |=> !s_tready, "second request taken while busy")

    // a non-final coefficient never raises a result right away
    `CHSE_ASSERT(a_no_early_result, s_tvalid && s_tready && !s_tlast |=> !$rose(m_tvalid), "result raised by non-final request")

endmodule

bind chebyshev_series_eval_3d_unit chse_checker u_chse_checker (.*);
